@@ rtl/core/preemptive_priority_scheduler_unit_assert.svh @@
// Assertion macros used by the checker file.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH

// Clocked assertion, masked while reset is high.
`define PPS_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define PPS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/pps_pkg.sv @@
`timescale 1ns / 1ps

package pps_pkg;

   // Fixed field widths
   localparam int SLOT_FIELD_W = 4;
   localparam int TIME_W       = 16;
   localparam int PRIO_W       = 8;
   localparam int TICK_W       = 32;
   localparam int CFG_W        = 5;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd1;

   // Default slot count of the table
   localparam int DEF_MAX_SLOTS = 16;

   // Digit-serial subtractor geometry
   localparam int DIGIT_W  = 4;
   localparam int N_DIGITS = TICK_W / DIGIT_W;

   // Item actions
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef struct packed {
      logic                    action;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [TIME_W-1:0]       arrival;
      logic [TIME_W-1:0]       burst;
      logic [PRIO_W-1:0]       prio;
   } req_type;

   typedef struct packed {
      logic                    idle;
      logic [SLOT_FIELD_W-1:0] chosen_slot;
      logic                    finished;
      logic [TICK_W-1:0]       finish_time;
      logic [TICK_W-1:0]       turnaround;
      logic [TICK_W-1:0]       waiting;
      logic                    all_done;
   } rsp_type;

   // Outcome of one slot scan, valid while done is high
   typedef struct packed {
      logic                    done;
      logic                    found;
      logic [SLOT_FIELD_W-1:0] best_slot;
      logic [TIME_W-1:0]       best_arrival;
      logic [TIME_W-1:0]       best_burst;
      logic                    last_tick;
      logic                    all_done;
   } scan_res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CALC,
      ST_HOLD
   } ctrl_state_type;

endpackage

@@ rtl/core/pps_slot_scan.sv @@
`timescale 1ns / 1ps

module pps_slot_scan #(
   parameter int MAX_SLOTS = pps_pkg::DEF_MAX_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load_en,
   input  logic [pps_pkg::SLOT_FIELD_W-1:0]  load_slot,
   input  logic [pps_pkg::TIME_W-1:0]        load_arrival,
   input  logic [pps_pkg::TIME_W-1:0]        load_burst,
   input  logic [pps_pkg::PRIO_W-1:0]        load_prio,
   input  logic                              scan_start,
   input  logic                              dec_en,
   input  logic [pps_pkg::TICK_W-1:0]        tick,
   input  logic [pps_pkg::CFG_W-1:0]         num_slots,
   output pps_pkg::scan_res_type             scan_res
);
   import pps_pkg::*;

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

   logic [TIME_W-1:0] arr_ff   [MAX_SLOTS];
   logic [TIME_W-1:0] burst_ff [MAX_SLOTS];
   logic [PRIO_W-1:0] prio_ff  [MAX_SLOTS];
   logic [TIME_W-1:0] rem_ff   [MAX_SLOTS];

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  nz_ff, nz_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] best_idx_ff, best_idx_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic [TIME_W-1:0] best_arr_ff, best_arr_in;
   logic [TIME_W-1:0] best_burst_ff, best_burst_in;
   logic [TIME_W-1:0] best_rem_ff, best_rem_in;

   logic [CNT_W-1:0]  n_used;
   logic [SLOT_W-1:0] cur;
   logic              in_range;
   logic              eligible;
   logic              last_tick;
   logic              load_ok;

   // Clamp the slot count to the table size
   assign n_used = (32'(num_slots) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(num_slots);
   assign cur      = ptr_ff[SLOT_W-1:0];
   assign in_range = (ptr_ff < n_used);
   assign eligible = in_range && ({{(TICK_W-TIME_W){1'b0}}, arr_ff[cur]} <= tick)
                     && (rem_ff[cur] != '0);
   assign last_tick = (best_rem_ff == TIME_W'(1));
   assign load_ok   = load_en && (32'(load_slot) < 32'(MAX_SLOTS));

   always_comb begin
      busy_in       = busy_ff;
      ptr_in        = ptr_ff;
      nz_in         = nz_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_prio_in  = best_prio_ff;
      best_arr_in   = best_arr_ff;
      best_burst_in = best_burst_ff;
      best_rem_in   = best_rem_ff;
      if (scan_start) begin
         busy_in  = 1'b1;
         ptr_in   = '0;
         nz_in    = '0;
         found_in = 1'b0;
      end else if (busy_ff) begin
         if (in_range) begin
            ptr_in = ptr_ff + CNT_W'(1);
            if (rem_ff[cur] != '0) begin
               nz_in = nz_ff + CNT_W'(1);
            end
            if (eligible && (!found_ff || (prio_ff[cur] < best_prio_ff))) begin
               found_in      = 1'b1;
               best_idx_in   = cur;
               best_prio_in  = prio_ff[cur];
               best_arr_in   = arr_ff[cur];
               best_burst_in = burst_ff[cur];
               best_rem_in   = rem_ff[cur];
            end
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         ptr_ff   <= '0;
         nz_ff    <= '0;
         found_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         ptr_ff   <= ptr_in;
         nz_ff    <= nz_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff   <= best_idx_in;
      best_prio_ff  <= best_prio_in;
      best_arr_ff   <= best_arr_in;
      best_burst_ff <= best_burst_in;
      best_rem_ff   <= best_rem_in;
   end

   // Slot table; loads and decrements never land in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            arr_ff[i]   <= '0;
            burst_ff[i] <= '0;
            prio_ff[i]  <= '0;
            rem_ff[i]   <= '0;
         end
      end else if (load_ok) begin
         arr_ff[SLOT_W'(load_slot)]   <= load_arrival;
         burst_ff[SLOT_W'(load_slot)] <= load_burst;
         prio_ff[SLOT_W'(load_slot)]  <= load_prio;
         rem_ff[SLOT_W'(load_slot)]   <= load_burst;
      end else if (dec_en) begin
         rem_ff[best_idx_ff] <= best_rem_ff - TIME_W'(1);
      end
   end

   always_comb begin
      scan_res.done         = busy_ff && !in_range;
      scan_res.found        = found_ff;
      scan_res.best_slot    = SLOT_FIELD_W'(best_idx_ff);
      scan_res.best_arrival = best_arr_ff;
      scan_res.best_burst   = best_burst_ff;
      scan_res.last_tick    = found_ff && last_tick;
      scan_res.all_done     = (nz_ff == '0)
                              || ((nz_ff == CNT_W'(1)) && found_ff && last_tick);
   end

endmodule

@@ rtl/core/pps_digit_sub.sv @@
`timescale 1ns / 1ps

module pps_digit_sub (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pps_pkg::TICK_W-1:0]  minuend,
   input  logic [pps_pkg::TIME_W-1:0]  sub_a,
   input  logic [pps_pkg::TIME_W-1:0]  sub_b,
   output logic                        done,
   output logic [pps_pkg::TICK_W-1:0]  diff_a,
   output logic [pps_pkg::TICK_W-1:0]  diff_b
);
   import pps_pkg::*;

   localparam int CNT_W = $clog2(N_DIGITS);

   logic [TICK_W-1:0]  m_sr_ff, m_sr_in;
   logic [TICK_W-1:0]  a_sr_ff, a_sr_in;
   logic [TICK_W-1:0]  b_sr_ff, b_sr_in;
   logic [TICK_W-1:0]  da_sr_ff, da_sr_in;
   logic [TICK_W-1:0]  db_sr_ff, db_sr_in;
   logic               bor_a_ff, bor_a_in;
   logic               bor_b_ff, bor_b_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic [DIGIT_W:0]   dig_a;
   logic [DIGIT_W:0]   dig_b;

   // First chain: minuend - a; second chain: (minuend - a) - b, one digit per cycle
   assign dig_a = {1'b0, m_sr_ff[DIGIT_W-1:0]} - {1'b0, a_sr_ff[DIGIT_W-1:0]}
                  - {{DIGIT_W{1'b0}}, bor_a_ff};
   assign dig_b = {1'b0, dig_a[DIGIT_W-1:0]} - {1'b0, b_sr_ff[DIGIT_W-1:0]}
                  - {{DIGIT_W{1'b0}}, bor_b_ff};

   always_comb begin
      m_sr_in  = m_sr_ff;
      a_sr_in  = a_sr_ff;
      b_sr_in  = b_sr_ff;
      da_sr_in = da_sr_ff;
      db_sr_in = db_sr_ff;
      bor_a_in = bor_a_ff;
      bor_b_in = bor_b_ff;
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      if (start) begin
         m_sr_in  = minuend;
         a_sr_in  = {{(TICK_W-TIME_W){1'b0}}, sub_a};
         b_sr_in  = {{(TICK_W-TIME_W){1'b0}}, sub_b};
         bor_a_in = 1'b0;
         bor_b_in = 1'b0;
         busy_in  = 1'b1;
         cnt_in   = '0;
      end else if (busy_ff) begin
         m_sr_in  = {{DIGIT_W{1'b0}}, m_sr_ff[TICK_W-1:DIGIT_W]};
         a_sr_in  = {{DIGIT_W{1'b0}}, a_sr_ff[TICK_W-1:DIGIT_W]};
         b_sr_in  = {{DIGIT_W{1'b0}}, b_sr_ff[TICK_W-1:DIGIT_W]};
         da_sr_in = {dig_a[DIGIT_W-1:0], da_sr_ff[TICK_W-1:DIGIT_W]};
         db_sr_in = {dig_b[DIGIT_W-1:0], db_sr_ff[TICK_W-1:DIGIT_W]};
         bor_a_in = dig_a[DIGIT_W];
         bor_b_in = dig_b[DIGIT_W];
         cnt_in   = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(N_DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      m_sr_ff  <= m_sr_in;
      a_sr_ff  <= a_sr_in;
      b_sr_ff  <= b_sr_in;
      da_sr_ff <= da_sr_in;
      db_sr_ff <= db_sr_in;
      bor_a_ff <= bor_a_in;
      bor_b_ff <= bor_b_in;
   end

   assign done   = done_ff;
   assign diff_a = da_sr_ff;
   // A final borrow means a negative second difference: clamp it
   assign diff_b = bor_b_ff ? '0 : db_sr_ff;

endmodule

@@ rtl/core/preemptive_priority_scheduler_unit.sv @@
// A tick item runs the scan, calc and hold states in turn to its result, the scan over the N slots in use;
// the slot scan reads one slot per cycle and the finish arithmetic runs a 4-bit digit per cycle.
// Items go in one at a time; a load item leaves the block ready for the next item, while a tick
// item holds off the next accept until its result is loaded into the output register.
// Reset (synchronous, active high) clears the slot table, the tick count and the result valid flag,
// and sets the slot count to one.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_unit #(
   parameter int MAX_SLOTS = pps_pkg::DEF_MAX_SLOTS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  pps_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output pps_pkg::rsp_type           rsp_data,
   input  logic                       csr_wr_en,
   input  logic [pps_pkg::CFG_W-1:0]  csr_wr_data
);
   import pps_pkg::*;

   ctrl_state_type    state_ff, state_in;

   logic [CFG_W-1:0]  num_slots_ff, num_slots_in;
   logic [TICK_W-1:0] tick_ff, tick_in;

   // Scan outcome captured at the end of the scan
   logic                    found_ff, found_in;
   logic [SLOT_FIELD_W-1:0] slot_ff, slot_in;
   logic                    fin_ff, fin_in;
   logic                    all_done_ff, all_done_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              req_accept;
   logic              load_en;
   logic              scan_start;
   logic              dec_en;
   logic              sub_start;
   logic              rsp_load;
   logic [TICK_W-1:0] tick_next;

   scan_res_type      scan_res;
   logic              sub_done;
   logic [TICK_W-1:0] sub_ta;
   logic [TICK_W-1:0] sub_wt;

   // Accept items only between ticks; a pending result does not block intake
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Saturating tick counter
   assign tick_next = (tick_ff == '1) ? tick_ff : tick_ff + TICK_W'(1);

   pps_slot_scan #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .load_en      (load_en),
      .load_slot    (req_data.slot),
      .load_arrival (req_data.arrival),
      .load_burst   (req_data.burst),
      .load_prio    (req_data.prio),
      .scan_start   (scan_start),
      .dec_en       (dec_en),
      .tick         (tick_ff),
      .num_slots    (num_slots_ff),
      .scan_res     (scan_res)
   );

   // Finish time is the updated tick count; turnaround and waiting follow from it
   pps_digit_sub u_sub (
      .clock   (clock),
      .reset   (reset),
      .start   (sub_start),
      .minuend (tick_next),
      .sub_a   (scan_res.best_arrival),
      .sub_b   (scan_res.best_burst),
      .done    (sub_done),
      .diff_a  (sub_ta),
      .diff_b  (sub_wt)
   );

   always_comb begin
      state_in     = state_ff;
      num_slots_in = csr_wr_en ? csr_wr_data : num_slots_ff;
      tick_in      = tick_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      fin_in       = fin_ff;
      all_done_in  = all_done_ff;
      load_en      = 1'b0;
      scan_start   = 1'b0;
      dec_en       = 1'b0;
      sub_start    = 1'b0;
      rsp_load     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.action == ACT_LOAD) begin
                  // Write the slot and stay ready for the next item
                  load_en = 1'b1;
               end else begin
                  scan_start = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_res.done) begin
               // Serve the winner, advance time, capture the outcome
               dec_en      = scan_res.found;
               tick_in     = tick_next;
               found_in    = scan_res.found;
               slot_in     = scan_res.best_slot;
               fin_in      = scan_res.last_tick;
               all_done_in = scan_res.all_done;
               state_in    = ST_CALC;
            end
         end
         ST_CALC: begin
            // Digit-serial subtraction runs from the first CALC cycle on
            if (sub_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // Wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Load the subtractor with the advanced tick count as the scan ends
      sub_start = (state_ff == ST_SCAN) && scan_res.done;
   end

   // Result item, zeroed where the outcome does not apply
   always_comb begin
      rsp_data_in             = rsp_data_ff;
      rsp_valid_in            = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.idle        = !found_ff;
         rsp_data_in.chosen_slot = found_ff ? slot_ff : '0;
         rsp_data_in.finished    = fin_ff;
         rsp_data_in.finish_time = fin_ff ? tick_ff : '0;
         rsp_data_in.turnaround  = fin_ff ? sub_ta : '0;
         rsp_data_in.waiting     = fin_ff ? sub_wt : '0;
         rsp_data_in.all_done    = all_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_slots_ff <= CFG_RESET;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         num_slots_ff <= num_slots_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff    <= found_in;
      slot_ff     <= slot_in;
      fin_ff      <= fin_in;
      all_done_ff <= all_done_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/core/pps_checker.sv @@
`timescale 1ns / 1ps
`include "preemptive_priority_scheduler_unit_assert.svh"

module pps_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  pps_pkg::rsp_type           rsp_data
);
   import pps_pkg::*;

   // Hold a stalled result item
   `PPS_ASSERT_RST(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data),
      "stalled result item changed")

   `PPS_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid,
      "result item shown right after reset")

   `PPS_ASSERT_RST(a_idle_clear, clock, reset,
      rsp_valid && rsp_data.idle |-> rsp_data.chosen_slot == '0 && !rsp_data.finished,
      "idle tick names a slot")

   `PPS_ASSERT_RST(a_unfinished_zero, clock, reset,
      rsp_valid && !rsp_data.finished |-> rsp_data.finish_time == '0
         && rsp_data.turnaround == '0 && rsp_data.waiting == '0,
      "timing fields set on unfinished tick")

   `PPS_ASSERT_RST(a_finish_order, clock, reset,
      rsp_valid && rsp_data.finished |-> rsp_data.turnaround <= rsp_data.finish_time
         && rsp_data.waiting <= rsp_data.turnaround && !rsp_data.idle,
      "finish times out of order")

endmodule

bind preemptive_priority_scheduler_unit pps_checker u_pps_checker (.*);

@@ dv/preemptive_priority_scheduler_unit_test.sv @@
`timescale 1ns / 1ps

module preemptive_priority_scheduler_unit_test;
   import pps_pkg::*;

   localparam int MAX_SLOTS = DEF_MAX_SLOTS;
   // Worst tick: one cycle per slot scanned plus the fixed arithmetic, taken twice over.
   localparam int DRAIN_CYCLES = 2 * (MAX_SLOTS + 11);
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 144;
   // Slot counts walked by the random part: full table, small, none, clamped, single, ...
   localparam logic [CFG_W-1:0] PHASE_COUNTS [N_PHASES] =
      '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd8, 5'd17, 5'd16};

   typedef enum logic {ROW_ITEM, ROW_COUNT} row_kind_type;

   // One line of the directed table: an item to send, or a slot-count write.
   typedef struct {
      row_kind_type     kind;
      logic [CFG_W-1:0] count;
      req_type          item;
      bit               known;   // result typed in by hand rather than predicted
      rsp_type          result;
   } stim_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   // Hand-typed result that travels alongside the item on the request channel.
   bit               known_en;
   rsp_type          known_rsp;

   // Scheduler state as the testbench sees it.
   logic [TIME_W-1:0] task_arrival [MAX_SLOTS] = '{default: '0};
   logic [TIME_W-1:0] task_burst   [MAX_SLOTS] = '{default: '0};
   logic [PRIO_W-1:0] task_prio    [MAX_SLOTS] = '{default: '0};
   logic [TIME_W-1:0] task_left    [MAX_SLOTS] = '{default: '0};
   logic [TICK_W-1:0] tick_now = '0;
   logic [CFG_W-1:0]  slot_count = CFG_RESET;

   rsp_type pending_results [$];
   rsp_type want_rsp;
   rsp_type got_rsp;
   rsp_type tick_rsp;
   int      error_count = 0;
   int      cycle_count = 0;
   int      gap_pct = 0;
   int      stall_pct = 0;
   int      stall_left = 0;

   stim_row_type directed_rows [$];

   preemptive_priority_scheduler_unit #(
      .MAX_SLOTS(MAX_SLOTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Apply one accepted item to the scheduler state. Return 1 when it yields a result.
   function automatic bit schedule_item(input req_type it, output rsp_type res);
      int                used;
      int                i;
      int                best;
      bit                found;
      logic [PRIO_W-1:0] best_prio;
      logic [TICK_W-1:0] span;
      res = '0;
      if (it.action == ACT_LOAD) begin
         // Reloading a busy slot just overwrites it.
         task_arrival[it.slot] = it.arrival;
         task_burst[it.slot]   = it.burst;
         task_prio[it.slot]    = it.prio;
         task_left[it.slot]    = it.burst;
         return 1'b0;
      end
      // Counts beyond the table size clamp to the table size.
      used = (slot_count > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
      found = 1'b0;
      best = 0;
      best_prio = '0;
      // Strict less-than keeps the lowest index on a priority tie.
      for (i = 0; i < used; i++) begin
         if (TICK_W'(task_arrival[i]) <= tick_now && task_left[i] != '0) begin
            if (!found || task_prio[i] < best_prio) begin
               found = 1'b1;
               best = i;
               best_prio = task_prio[i];
            end
         end
      end
      // The tick counter saturates rather than wrapping.
      if (tick_now != '1)
         tick_now = tick_now + 1'b1;
      if (found) begin
         task_left[best] = task_left[best] - 1'b1;
         if (task_left[best] == '0) begin
            span = tick_now - TICK_W'(task_arrival[best]);
            res.finished    = 1'b1;
            res.finish_time = tick_now;
            res.turnaround  = span;
            res.waiting     = (span >= TICK_W'(task_burst[best])) ?
                              span - TICK_W'(task_burst[best]) : '0;
         end
      end
      res.idle = !found;
      res.chosen_slot = found ? best[SLOT_FIELD_W-1:0] : '0;
      res.all_done = 1'b1;
      for (i = 0; i < used; i++) begin
         if (task_left[i] != '0)
            res.all_done = 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic stim_row_type load_row(input logic [SLOT_FIELD_W-1:0] s,
                                             input logic [TIME_W-1:0] arr,
                                             input logic [TIME_W-1:0] len,
                                             input logic [PRIO_W-1:0] p);
      stim_row_type r;
      r = '{ROW_ITEM, '0, '0, 1'b0, '0};
      r.item.action  = ACT_LOAD;
      r.item.slot    = s;
      r.item.arrival = arr;
      r.item.burst   = len;
      r.item.prio    = p;
      return r;
   endfunction

   function automatic stim_row_type tick_row();
      stim_row_type r;
      r = '{ROW_ITEM, '0, '0, 1'b0, '0};
      r.item.action = ACT_TICK;
      return r;
   endfunction

   // Tick whose result is plain to see: typed in rather than predicted.
   function automatic stim_row_type tick_known(input logic idle,
                                               input logic [SLOT_FIELD_W-1:0] s,
                                               input logic fin, input logic [TICK_W-1:0] ft,
                                               input logic [TICK_W-1:0] ta,
                                               input logic [TICK_W-1:0] wt,
                                               input logic done);
      stim_row_type r;
      r = tick_row();
      r.known = 1'b1;
      r.result = '{idle, s, fin, ft, ta, wt, done};
      return r;
   endfunction

   function automatic stim_row_type count_row(input logic [CFG_W-1:0] v);
      stim_row_type r;
      r = '{ROW_COUNT, v, '0, 1'b0, '0};
      return r;
   endfunction

   // Drive one item at the falling edge and hold it until the block takes it.
   task automatic send_item(input req_type it, input bit known, input rsp_type result);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      known_en  <= known;
      known_rsp <= result;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   // Drop valid, wait for every result, then let a trailing load item settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write the slot count only with the block idle.
   task automatic set_slot_count(input logic [CFG_W-1:0] count);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      slot_count = count;
   endtask

   // Receiver: stall in random bursts, at the rate of the current phase.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 8);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: check the result leaving first, then predict from the item entering.
   // Both are sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got_rsp = rsp_data;
            if (pending_results.size() == 0) begin
               $error("result with no item pending: %p", got_rsp);
               error_count++;
            end else begin
               want_rsp = pending_results.pop_front();
               if (got_rsp.idle !== want_rsp.idle) begin
                  $error("idle: expected %0d, got %0d", want_rsp.idle, got_rsp.idle);
                  error_count++;
               end
               if (got_rsp.chosen_slot !== want_rsp.chosen_slot) begin
                  $error("chosen_slot: expected %0d, got %0d",
                         want_rsp.chosen_slot, got_rsp.chosen_slot);
                  error_count++;
               end
               if (got_rsp.finished !== want_rsp.finished) begin
                  $error("finished: expected %0d, got %0d",
                         want_rsp.finished, got_rsp.finished);
                  error_count++;
               end
               if (got_rsp.finish_time !== want_rsp.finish_time) begin
                  $error("finish_time: expected %0d, got %0d",
                         want_rsp.finish_time, got_rsp.finish_time);
                  error_count++;
               end
               if (got_rsp.turnaround !== want_rsp.turnaround) begin
                  $error("turnaround: expected %0d, got %0d",
                         want_rsp.turnaround, got_rsp.turnaround);
                  error_count++;
               end
               if (got_rsp.waiting !== want_rsp.waiting) begin
                  $error("waiting: expected %0d, got %0d",
                         want_rsp.waiting, got_rsp.waiting);
                  error_count++;
               end
               if (got_rsp.all_done !== want_rsp.all_done) begin
                  $error("all_done: expected %0d, got %0d",
                         want_rsp.all_done, got_rsp.all_done);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            // Advance the state on every item; a hand-typed result replaces the prediction.
            if (schedule_item(req_data, tick_rsp))
               pending_results.push_back(known_en ? known_rsp : tick_rsp);
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("preemptive_priority_scheduler_unit_test: errors");
         $finish;
      end
   end

   initial begin
      req_type it;
      int      row;
      int      phase;
      int      k;
      int      used;
      int      near;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      known_en    = 1'b0;
      known_rsp   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = CFG_RESET;

      // Directed part, starting from one slot in use after reset.
      directed_rows = '{
         // Empty table: idle tick, everything done.
         tick_known(1'b1, 4'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1),
         // Lowest priority, one tick of service: done at tick 2.
         load_row(4'd0, 16'd0, 16'd1, 8'd255),
         tick_known(1'b0, 4'd0, 1'b1, 32'd2, 32'd2, 32'd1, 1'b1),
         // Latest arrival and longest burst: pending but never eligible yet.
         load_row(4'd0, 16'hFFFF, 16'hFFFF, 8'd0),
         tick_known(1'b1, 4'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0),
         count_row(5'd16),
         // Zero burst in the top slot: never served.
         load_row(4'd15, 16'd0, 16'd0, 8'd0),
         // Equal priorities: lower index first.
         load_row(4'd3, 16'd0, 16'd2, 8'd7),
         load_row(4'd9, 16'd0, 16'd1, 8'd7),
         // Late arrival with the best priority preempts.
         load_row(4'd12, 16'd5, 16'd1, 8'd0),
         tick_row(),
         tick_row(),
         tick_row(),
         // Reload a slot that still has work left.
         load_row(4'd0, 16'd0, 16'd3, 8'd200),
         tick_row(),
         tick_row(),
         load_row(4'd5, 16'd0, 16'd2, 8'd200),
         tick_row(),
         tick_row(),
         // No slot in use: idle and all done.
         count_row(5'd0),
         tick_known(1'b1, 4'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1),
         // Count above the table size clamps to the full table.
         count_row(5'd31),
         tick_row(),
         tick_row(),
         tick_row(),
         tick_row()
      };

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      gap_pct   = 25;
      stall_pct = 25;
      for (row = 0; row < directed_rows.size(); row++) begin
         if (directed_rows[row].kind == ROW_COUNT)
            set_slot_count(directed_rows[row].count);
         else
            send_item(directed_rows[row].item, directed_rows[row].known,
                      directed_rows[row].result);
      end

      // Random part: one phase per slot count. Mostly well-formed loads near the current
      // tick with short bursts, so tasks arrive, compete, preempt and finish.
      for (phase = 0; phase < N_PHASES; phase++) begin
         set_slot_count(PHASE_COUNTS[phase]);
         if (phase == N_PHASES - 1 || phase == 2) begin
            // Run flat out: no gaps, no stalls.
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = $urandom_range(10, 40);
            stall_pct = $urandom_range(10, 40);
         end
         used = (slot_count > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            // Fill every field at random; ticks ignore all but the action.
            it.slot    = SLOT_FIELD_W'($urandom_range(0, 15));
            it.arrival = TIME_W'($urandom_range(0, 65535));
            it.burst   = TIME_W'($urandom_range(0, 65535));
            it.prio    = PRIO_W'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 55) begin
               it.action = ACT_TICK;
            end else begin
               it.action = ACT_LOAD;
               if (used != 0 && $urandom_range(0, 9) != 0)
                  it.slot = SLOT_FIELD_W'($urandom_range(0, used - 1));
               // A few loads keep their raw values as noise.
               if ($urandom_range(0, 24) != 0) begin
                  near = int'(tick_now) + int'($urandom_range(0, 12)) - 3;
                  if (near < 0)
                     near = 0;
                  it.arrival = near[TIME_W-1:0];
                  it.burst   = TIME_W'($urandom_range(0, 5));
                  // Narrow priorities half the time to force ties.
                  if ($urandom_range(0, 1) != 0)
                     it.prio = PRIO_W'($urandom_range(0, 3));
               end
            end
            send_item(it, 1'b0, '0);
         end
      end

      wait_drained();
      if (error_count == 0)
         $display("preemptive_priority_scheduler_unit_test: clean");
      else
         $display("preemptive_priority_scheduler_unit_test: errors");
      $finish;
   end

endmodule
